// ----- rtl/bfsp_pkg.sv -----
// Shared constants, operation codes and controller/datapath interface structs
// for the shortest-path unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfsp_pkg;

   localparam int MAX_VERTICES   = 16;
   localparam int WEIGHT_BITS    = 16;
   localparam int KIND_BITS      = 2;
   localparam int VERTEX_BITS    = 4;
   localparam int WEIGHT_IN_BITS = 16;
   localparam int DIST_BITS      = 20;
   localparam int CSR_BITS       = 5;
   localparam int CSR_RESET      = 16;

   localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_COMPUTE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd2;

   localparam logic RESULT_STATUS = 1'b0;
   localparam logic RESULT_READ   = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic init;
      logic row_read;
      logic latch_row;
      logic pair_read;
      logic pair_exec;
      logic emit_load;
   } bfsp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic src_ok;
      logic last_v;
      logic found;
      logic walk_done;
      logic out_free;
   } bfsp_status_type;

endpackage

`default_nettype wire

// ----- rtl/bfsp_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// ----- rtl/bfsp_ctrl.sv -----
// Sequencer for the shortest-path unit: reset clearing, transaction intake,
// relaxation walk and result hand-off. Uses bfsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [bfsp_pkg::KIND_BITS-1:0]   req_kind,
   input  wire bfsp_pkg::bfsp_status_type        status,
   output bfsp_pkg::bfsp_cmd_type                cmd
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_INIT    = 3'd2;
   localparam logic [2:0] S_ROW     = 3'd3;
   localparam logic [2:0] S_LATCH   = 3'd4;
   localparam logic [2:0] S_PAIR_RD = 3'd5;
   localparam logic [2:0] S_PAIR_EX = 3'd6;
   localparam logic [2:0] S_EMIT    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.clear_step = (state_ff == S_CLEAR);
      cmd.accept     = accept;
      cmd.init       = (state_ff == S_INIT);
      cmd.row_read   = (state_ff == S_ROW);
      cmd.latch_row  = (state_ff == S_LATCH);
      cmd.pair_read  = (state_ff == S_PAIR_RD);
      cmd.pair_exec  = (state_ff == S_PAIR_EX);
      cmd.emit_load  = (state_ff == S_EMIT) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  bfsp_pkg::KIND_COMPUTE: state_in = S_INIT;
                  bfsp_pkg::KIND_READ:    state_in = S_EMIT;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            state_in = status.src_ok ? S_ROW : S_EMIT;
         end
         S_ROW:     state_in = S_LATCH;
         S_LATCH:   state_in = S_PAIR_RD;
         S_PAIR_RD: state_in = S_PAIR_EX;
         S_PAIR_EX: begin
            if (status.found || status.walk_done) begin
               state_in = S_EMIT;
            end else if (status.last_v) begin
               state_in = S_ROW;
            end else begin
               state_in = S_PAIR_RD;
            end
         end
         S_EMIT: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/bfsp_datapath.sv -----
// Datapath of the shortest-path unit: edge and distance memories, walk
// counters, relaxation arithmetic and result register. Uses bfsp_pkg, bfsp_ram.
`timescale 1ns / 1ps
`default_nettype none

module bfsp_datapath #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES,
   parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire bfsp_pkg::bfsp_cmd_type                  cmd,
   output bfsp_pkg::bfsp_status_type                    status,
   input  wire logic [bfsp_pkg::KIND_BITS-1:0]          req_kind,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]        req_from_vertex,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]        req_to_vertex,
   input  wire logic                                    req_edge_present,
   input  wire logic signed [bfsp_pkg::WEIGHT_IN_BITS-1:0] req_edge_weight,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]        req_source_vertex,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]        req_target_vertex,
   input  wire logic                                    csr_write_enable,
   input  wire logic [bfsp_pkg::CSR_BITS-1:0]           csr_write_data,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_result_type,
   output logic                                         rsp_no_negative_cycle,
   output logic                                         rsp_reachable,
   output logic signed [bfsp_pkg::DIST_BITS-1:0]        rsp_distance
);

   localparam int VW        = $clog2(MAX_VERTICES);
   localparam int CW        = (VW + 1 > bfsp_pkg::CSR_BITS) ? VW + 1 : bfsp_pkg::CSR_BITS;
   localparam int CELL_BITS = 2 * VW;
   localparam int CELLS     = 1 << CELL_BITS;
   localparam int EW        = WEIGHT_BITS + 1;
   localparam int WIN       = bfsp_pkg::WEIGHT_IN_BITS;
   localparam int IW        = (WEIGHT_BITS > WIN) ? WEIGHT_BITS : WIN;
   localparam int DW        = bfsp_pkg::DIST_BITS;
   localparam int SW        = ((DW > WEIGHT_BITS) ? DW : WEIGHT_BITS) + 2;
   localparam int DIST_MAX  = (1 << (DW - 1)) - 1;

   localparam logic [CW-1:0] N_MAX = CW'(MAX_VERTICES);
   localparam logic [CW-1:0] N_ONE = CW'(1);
   localparam logic [CW-1:0] N_TWO = CW'(2);
   localparam logic signed [IW-1:0] W_HI =
      {{(IW - WEIGHT_BITS + 1){1'b0}}, {(WEIGHT_BITS - 1){1'b1}}};
   localparam logic signed [IW-1:0] W_LO = ~W_HI;
   localparam logic signed [SW-1:0] SUM_MAX = SW'(DIST_MAX);
   localparam logic signed [SW-1:0] SUM_MIN = SW'(-DIST_MAX - 1);

   // configuration and status
   logic [bfsp_pkg::CSR_BITS-1:0] csr_ff;
   logic                          cycle_status_ff, cycle_status_in;
   logic [CW-1:0]                 n_count;

   // walk state
   logic [CELL_BITS-1:0]          clr_ff;
   logic [VW-1:0]                 u_ff, u_in, v_ff, v_in;
   logic [CW-1:0]                 pass_ff, pass_in;
   logic                          check_ff, check_in;
   logic signed [DW-1:0]          du_ff, du_in;
   logic [MAX_VERTICES-1:0]       dvalid_ff, dvalid_in;
   logic [bfsp_pkg::VERTEX_BITS-1:0] src_ff;
   logic                          read_ok_ff;
   logic                          res_kind_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_type_ff;
   logic                          rsp_noneg_ff;
   logic                          rsp_reach_ff;
   logic signed [DW-1:0]          rsp_dist_ff;

   // memories
   logic                 edge_we, edge_re;
   logic [CELL_BITS-1:0] edge_waddr, edge_raddr;
   logic [EW-1:0]        edge_wdata, edge_rdata;
   logic                 dist_we, dist_re;
   logic [VW-1:0]        dist_waddr, dist_raddr;
   logic [DW-1:0]        dist_wdata, dist_rdata;

   logic [CW-1:0]           from_ext, to_ext, tgt_ext, src_ext, u_ext, v_ext;
   logic                    cell_ok, tgt_ok, src_ok;
   logic signed [IW-1:0]    w_ext, w_sat;
   logic signed [WEIGHT_BITS-1:0] edge_w;
   logic signed [SW-1:0]    sum, sum_sat;
   logic                    improve, relax_update, last_v, last_u, last_pass;
   logic                    accept_read;

   assign n_count = (csr_ff == '0) ? N_ONE :
                    ((CW'(csr_ff) > N_MAX) ? N_MAX : CW'(csr_ff));

   assign from_ext = CW'(req_from_vertex);
   assign to_ext   = CW'(req_to_vertex);
   assign tgt_ext  = CW'(req_target_vertex);
   assign src_ext  = CW'(src_ff);
   assign u_ext    = CW'(u_ff);
   assign v_ext    = CW'(v_ff);
   assign cell_ok  = (from_ext < N_MAX) && (to_ext < N_MAX);
   assign tgt_ok   = (tgt_ext < N_MAX);
   assign src_ok   = (src_ext < n_count);

   assign w_ext = IW'(req_edge_weight);
   assign w_sat = (w_ext > W_HI) ? W_HI : ((w_ext < W_LO) ? W_LO : w_ext);

   assign accept_read = cmd.accept && (req_kind == bfsp_pkg::KIND_READ);

   assign edge_we    = cmd.clear_step ||
                       (cmd.accept && (req_kind == bfsp_pkg::KIND_WRITE) && cell_ok);
   assign edge_waddr = cmd.clear_step ? clr_ff : {from_ext[VW-1:0], to_ext[VW-1:0]};
   assign edge_wdata = (cmd.clear_step || !req_edge_present) ? '0 :
                       {1'b1, w_sat[WEIGHT_BITS-1:0]};
   assign edge_re    = cmd.pair_read;
   assign edge_raddr = {u_ff, v_ff};

   assign edge_w  = signed'(edge_rdata[WEIGHT_BITS-1:0]);
   assign sum     = SW'(du_ff) + SW'(edge_w);
   assign improve = edge_rdata[WEIGHT_BITS] && dvalid_ff[u_ff] &&
                    (!dvalid_ff[v_ff] || (sum < SW'(signed'(dist_rdata))));
   assign sum_sat = (sum > SUM_MAX) ? SUM_MAX : ((sum < SUM_MIN) ? SUM_MIN : sum);
   assign relax_update = !check_ff && improve;

   assign last_v    = (v_ext == n_count - N_ONE);
   assign last_u    = (u_ext == n_count - N_ONE);
   assign last_pass = (pass_ff == n_count - N_TWO);

   assign dist_we    = (cmd.init && src_ok) || (cmd.pair_exec && relax_update);
   assign dist_waddr = cmd.init ? src_ext[VW-1:0] : v_ff;
   assign dist_wdata = cmd.init ? '0 : sum_sat[DW-1:0];
   assign dist_re    = cmd.row_read || cmd.pair_read || accept_read;
   assign dist_raddr = cmd.row_read ? u_ff : (cmd.pair_read ? v_ff : tgt_ext[VW-1:0]);

   bfsp_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_edge_ram (
      .clock        (clock),
      .write_enable (edge_we),
      .write_addr   (edge_waddr),
      .write_data   (edge_wdata),
      .read_enable  (edge_re),
      .read_addr    (edge_raddr),
      .read_data    (edge_rdata)
   );

   bfsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock        (clock),
      .write_enable (dist_we),
      .write_addr   (dist_waddr),
      .write_data   (dist_wdata),
      .read_enable  (dist_re),
      .read_addr    (dist_raddr),
      .read_data    (dist_rdata)
   );

   always_comb begin
      u_in            = u_ff;
      v_in            = v_ff;
      pass_in         = pass_ff;
      check_in        = check_ff;
      du_in           = du_ff;
      dvalid_in       = dvalid_ff;
      cycle_status_in = cycle_status_ff;
      if (cmd.init) begin
         u_in      = '0;
         v_in      = '0;
         pass_in   = '0;
         check_in  = (n_count == N_ONE);
         dvalid_in = '0;
         if (src_ok) begin
            dvalid_in[src_ext[VW-1:0]] = 1'b1;
         end else begin
            cycle_status_in = 1'b1;
         end
      end
      if (cmd.latch_row) begin
         du_in = signed'(dist_rdata);
      end
      if (cmd.pair_exec) begin
         if (relax_update) begin
            dvalid_in[v_ff] = 1'b1;
            if (u_ff == v_ff) du_in = sum_sat[DW-1:0];
         end
         if (check_ff && improve) begin
            cycle_status_in = 1'b0;
         end else if (check_ff && last_v && last_u) begin
            cycle_status_in = 1'b1;
         end
         if (last_v) begin
            v_in = '0;
            if (last_u) begin
               u_in = '0;
               if (!check_ff) begin
                  if (last_pass) check_in = 1'b1;
                  else pass_in = pass_ff + N_ONE;
               end
            end else begin
               u_in = u_ff + VW'(1);
            end
         end else begin
            v_in = v_ff + VW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff          <= bfsp_pkg::CSR_BITS'(bfsp_pkg::CSR_RESET);
         cycle_status_ff <= 1'b1;
         clr_ff          <= '0;
         dvalid_ff       <= '0;
         check_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) csr_ff <= csr_write_data;
         if (cmd.clear_step) clr_ff <= clr_ff + CELL_BITS'(1);
         cycle_status_ff <= cycle_status_in;
         dvalid_ff       <= dvalid_in;
         check_ff        <= check_in;
         if (cmd.emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff    <= u_in;
      v_ff    <= v_in;
      pass_ff <= pass_in;
      du_ff   <= du_in;
      if (cmd.accept) begin
         src_ff      <= req_source_vertex;
         read_ok_ff  <= tgt_ok && dvalid_ff[tgt_ext[VW-1:0]];
         res_kind_ff <= (req_kind == bfsp_pkg::KIND_READ) ?
                        bfsp_pkg::RESULT_READ : bfsp_pkg::RESULT_STATUS;
      end
      if (cmd.emit_load) begin
         rsp_type_ff  <= res_kind_ff;
         rsp_noneg_ff <= cycle_status_ff;
         rsp_reach_ff <= (res_kind_ff == bfsp_pkg::RESULT_READ) && read_ok_ff;
         rsp_dist_ff  <= ((res_kind_ff == bfsp_pkg::RESULT_READ) && read_ok_ff) ?
                         signed'(dist_rdata) : '0;
      end
   end

   assign status.clear_done = &clr_ff;
   assign status.src_ok     = src_ok;
   assign status.last_v     = last_v;
   assign status.found      = check_ff && improve;
   assign status.walk_done  = check_ff && last_v && last_u;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_type       = rsp_type_ff;
   assign rsp_no_negative_cycle = rsp_noneg_ff;
   assign rsp_reachable         = rsp_reach_ff;
   assign rsp_distance          = rsp_dist_ff;

`ifndef SYNTH
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |=> rsp_valid_ff)
      else $error("result load did not raise rsp_valid");

   a_relax_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.pair_exec && relax_update) |=> dvalid_ff[$past(v_ff)])
      else $error("relaxed vertex not marked reachable");

   a_bad_source: assert property (@(posedge clock) disable iff (reset)
      (cmd.init && !src_ok) |=> cycle_status_ff)
      else $error("out-of-range source must report no negative cycle");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_type_ff == bfsp_pkg::RESULT_STATUS))
         |-> (!rsp_reach_ff && (rsp_dist_ff == '0)))
      else $error("status transaction carries distance data");
`endif

endmodule

`default_nettype wire

// ----- rtl/bellman_ford_shortest_paths_unit.sv -----
// Top level of the single-source shortest-path unit.
// Depends on bfsp_pkg, bfsp_ctrl, bfsp_datapath (and through it bfsp_ram).
`timescale 1ns / 1ps
`default_nettype none

// Bellman-Ford shortest paths over a directed graph of up to MAX_VERTICES
// vertices held in an adjacency-matrix RAM. After reset the edge RAM is swept
// to "no edge", one cell per cycle, over all (2**clog2(MAX_VERTICES))**2 cells
// (256 at the default size); no transaction is taken during the sweep, CSR
// writes are. An edge write goes to the edge RAM in the cycle it is taken. A
// distance read is taken in the idle state and loads the result register in
// the emit state once the result register is free; rsp_valid rises in the
// cycle after that load. A compute transaction walks every vertex pair once
// per pass through a single relax unit, a read step and an execute step per
// pair after a row-distance fetch for each row; the final check pass ends
// early when a negative cycle is found, and the walk is skipped when the
// source is not in use. One transaction is worked on at a time; the next is
// taken while a finished result still waits on rsp_stall, and a second
// finished result holds the input until the first one is taken.

module bellman_ford_shortest_paths_unit #(
   parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES,
   parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic [bfsp_pkg::KIND_BITS-1:0]             req_kind,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]           req_from_vertex,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]           req_to_vertex,
   input  wire logic                                       req_edge_present,
   input  wire logic signed [bfsp_pkg::WEIGHT_IN_BITS-1:0] req_edge_weight,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]           req_source_vertex,
   input  wire logic [bfsp_pkg::VERTEX_BITS-1:0]           req_target_vertex,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic                                            rsp_result_type,
   output logic                                            rsp_no_negative_cycle,
   output logic                                            rsp_reachable,
   output logic signed [bfsp_pkg::DIST_BITS-1:0]           rsp_distance,
   input  wire logic                                       csr_write_enable,
   input  wire logic [bfsp_pkg::CSR_BITS-1:0]              csr_write_data
);

   bfsp_pkg::bfsp_cmd_type    cmd;
   bfsp_pkg::bfsp_status_type status;

   bfsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   bfsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_kind              (req_kind),
      .req_from_vertex       (req_from_vertex),
      .req_to_vertex         (req_to_vertex),
      .req_edge_present      (req_edge_present),
      .req_edge_weight       (req_edge_weight),
      .req_source_vertex     (req_source_vertex),
      .req_target_vertex     (req_target_vertex),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_type       (rsp_result_type),
      .rsp_no_negative_cycle (rsp_no_negative_cycle),
      .rsp_reachable         (rsp_reachable),
      .rsp_distance          (rsp_distance)
   );

endmodule

`default_nettype wire
